// ----- rtl/rc4s_pkg.sv -----
// Shared types, constants and the control program of the sectioned RC4 engine.
`default_nettype none

package rc4s_pkg;

   localparam int BYTE_W            = 8;
   localparam int PERM_DEPTH        = 256;
   localparam int PERM_AW           = $clog2(PERM_DEPTH);
   localparam int SECTION_BYTES_DEF = 512;
   localparam int MAX_KEY_BYTES_DEF = 256;

   localparam int KEY_LEN_W = 9;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd1;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LENGTH = 2'd0;

   // Request commands.
   localparam logic CMD_KEY_WRITE = 1'b0;
   localparam logic CMD_DATA      = 1'b1;

   // Step numbers of the control program.
   typedef logic [3:0] step_type;
   localparam step_type STEP_IDLE    = 4'd0;
   localparam step_type STEP_KS_INIT = 4'd1;
   localparam step_type STEP_KS_A    = 4'd2;
   localparam step_type STEP_KS_B    = 4'd3;
   localparam step_type STEP_KS_C    = 4'd4;
   localparam step_type STEP_KS_D    = 4'd5;
   localparam step_type STEP_P0      = 4'd6;
   localparam step_type STEP_P1      = 4'd7;
   localparam step_type STEP_P2      = 4'd8;
   localparam step_type STEP_P3      = 4'd9;
   localparam step_type STEP_P4      = 4'd10;

   typedef enum logic [2:0] {
      RA_I,
      RA_J_NEXT,
      RA_X_NEXT,
      RA_Y_NEXT,
      RA_AB
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_I,
      WA_J,
      WA_X,
      WA_Y
   } wa_sel_type;

   typedef enum logic [1:0] {
      WD_I,
      WD_RD,
      WD_T
   } wd_sel_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_JUMP,
      JC_LOOP_I,
      JC_DISPATCH
   } jc_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wa_sel_type wa_sel;
      wd_sel_type wd_sel;
      logic       we;
      logic       ld_t;
      logic       ld_j;
      logic       ld_x;
      logic       ld_y;
      logic       ld_b;
      logic       ld_hit;
      logic       ld_out;
      logic       inc_i;
      logic       inc_k;
      logic       clr;
   } dp_ctl_type;

   typedef struct packed {
      dp_ctl_type dp;
      logic       take;
      jc_type     jc;
      step_type   target;
   } ucode_type;

   typedef struct packed {
      logic i_last;
      logic rsp_busy;
      logic rekey;
   } dp_status_type;

   // Control program. The schedule fills the table, then mixes it with the key
   // in four steps per entry; a data byte takes five steps.
   function automatic ucode_type ucode_rom(input step_type pc);
      ucode_type w;
      w = '0;
      case (pc)
         STEP_IDLE: begin
            w.take = 1'b1;
            w.jc   = JC_DISPATCH;
         end
         STEP_KS_INIT: begin
            w.dp.we     = 1'b1;
            w.dp.wa_sel = WA_I;
            w.dp.wd_sel = WD_I;
            w.dp.inc_i  = 1'b1;
            w.dp.clr    = 1'b1;
            w.jc        = JC_LOOP_I;
            w.target    = STEP_KS_INIT;
         end
         STEP_KS_A: begin
            w.dp.rd_sel = RA_I;
            w.jc        = JC_NEXT;
         end
         STEP_KS_B: begin
            w.dp.rd_sel = RA_J_NEXT;
            w.dp.ld_t   = 1'b1;
            w.dp.ld_j   = 1'b1;
            w.jc        = JC_NEXT;
         end
         STEP_KS_C: begin
            w.dp.we     = 1'b1;
            w.dp.wa_sel = WA_I;
            w.dp.wd_sel = WD_RD;
            w.jc        = JC_NEXT;
         end
         STEP_KS_D: begin
            w.dp.we     = 1'b1;
            w.dp.wa_sel = WA_J;
            w.dp.wd_sel = WD_T;
            w.dp.inc_i  = 1'b1;
            w.dp.inc_k  = 1'b1;
            w.jc        = JC_LOOP_I;
            w.target    = STEP_KS_A;
         end
         STEP_P0: begin
            w.dp.rd_sel = RA_X_NEXT;
            w.dp.ld_x   = 1'b1;
            w.jc        = JC_NEXT;
         end
         STEP_P1: begin
            w.dp.rd_sel = RA_Y_NEXT;
            w.dp.ld_t   = 1'b1;
            w.dp.ld_y   = 1'b1;
            w.jc        = JC_NEXT;
         end
         STEP_P2: begin
            w.dp.we     = 1'b1;
            w.dp.wa_sel = WA_X;
            w.dp.wd_sel = WD_RD;
            w.dp.ld_b   = 1'b1;
            w.jc        = JC_NEXT;
         end
         STEP_P3: begin
            w.dp.we     = 1'b1;
            w.dp.wa_sel = WA_Y;
            w.dp.wd_sel = WD_T;
            w.dp.rd_sel = RA_AB;
            w.dp.ld_hit = 1'b1;
            w.jc        = JC_NEXT;
         end
         STEP_P4: begin
            w.dp.rd_sel = RA_AB;
            w.dp.ld_out = 1'b1;
            w.take      = 1'b1;
            w.jc        = JC_DISPATCH;
         end
         default: begin
            w.jc     = JC_JUMP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rc4s_sequencer.sv -----
// Step counter and control program sequencer of the sectioned RC4 engine.
`default_nettype none

module rc4s_sequencer
   import rc4s_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_cmd,
   input  wire dp_status_type status,
   output      dp_ctl_type    ctl,
   output      logic          req_stall,
   output      logic          key_go,
   output      logic          item_go
);

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type word;
   logic      hold;
   logic      accept;

   assign word = ucode_rom(pc_ff);

   // The last step of a byte waits while the previous result is still stalled.
   assign hold      = word.dp.ld_out & status.rsp_busy;
   assign req_stall = ~(word.take & ~hold);
   assign accept    = req_valid & ~req_stall;
   assign item_go   = accept & (req_cmd == CMD_DATA);
   assign key_go    = accept & (req_cmd == CMD_KEY_WRITE);

   always_comb begin
      ctl        = word.dp;
      ctl.ld_out = word.dp.ld_out & ~hold;
   end

   always_comb begin
      case (word.jc)
         JC_NEXT:   pc_in = pc_ff + 4'd1;
         JC_JUMP:   pc_in = word.target;
         JC_LOOP_I: pc_in = status.i_last ? pc_ff + 4'd1 : word.target;
         JC_DISPATCH: begin
            if (hold) begin
               pc_in = pc_ff;
            end else if (item_go) begin
               pc_in = status.rekey ? STEP_KS_INIT : STEP_P0;
            end else begin
               pc_in = STEP_IDLE;
            end
         end
         default:   pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rc4s_datapath.sv -----
// Datapath of the sectioned RC4 engine: permutation and key memories, indices, result register.
`default_nettype none

module rc4s_datapath
   import rc4s_pkg::*;
#(
   parameter int SECTION_BYTES = SECTION_BYTES_DEF,
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_ctl_type           ctl,
   input  wire logic                 key_go,
   input  wire logic                 item_go,
   input  wire logic [KEY_LEN_W-1:0] key_length,
   input  wire logic [7:0]           req_key_index,
   input  wire logic [7:0]           req_byte_value,
   input  wire logic                 req_message_start,
   input  wire logic                 rsp_stall,
   output      dp_status_type        status,
   output      logic                 rsp_valid,
   output      logic [7:0]           rsp_out_byte
);

   localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int SECT_W = $clog2(SECTION_BYTES) + 1;
   localparam logic [SECT_W-1:0]    SECT_LAST   = SECT_W'(SECTION_BYTES - 1);
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = KEY_LEN_W'(MAX_KEY_BYTES);
   localparam logic [PERM_AW-1:0]   I_LAST      = PERM_AW'(PERM_DEPTH - 1);

   logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
   logic [BYTE_W-1:0] key_mem  [MAX_KEY_BYTES];

   logic [PERM_AW-1:0] i_ff, i_in;
   logic [PERM_AW-1:0] j_ff, j_in;
   logic [PERM_AW-1:0] x_ff, x_in;
   logic [PERM_AW-1:0] y_ff, y_in;
   logic [KEY_AW-1:0]  k_ff, k_in;
   logic [SECT_W-1:0]  sect_ff, sect_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [BYTE_W-1:0]  rd_ff;
   logic [BYTE_W-1:0]  kd_ff;
   logic [BYTE_W-1:0]  t_ff;
   logic [BYTE_W-1:0]  b_ff;
   logic               hit_ff;
   logic [BYTE_W-1:0]  val_ff;
   logic [BYTE_W-1:0]  out_byte_ff;

   logic [PERM_AW-1:0]   j_sum;
   logic [PERM_AW-1:0]   ab_sum;
   logic [PERM_AW-1:0]   rd_addr;
   logic [PERM_AW-1:0]   wr_addr;
   logic [BYTE_W-1:0]    wr_data;
   logic [KEY_LEN_W-1:0] len_eff;
   logic [KEY_LEN_W-1:0] k_inc;
   logic [SECT_W-1:0]    sect_inc;
   logic                 key_we;
   logic [BYTE_W-1:0]    ks;

   assign j_sum  = j_ff + rd_ff + kd_ff;
   assign ab_sum = t_ff + b_ff;

   always_comb begin
      case (ctl.rd_sel)
         RA_I:      rd_addr = i_ff;
         RA_J_NEXT: rd_addr = j_sum;
         RA_X_NEXT: rd_addr = x_ff + 8'd1;
         RA_Y_NEXT: rd_addr = y_ff + rd_ff;
         RA_AB:     rd_addr = ab_sum;
         default:   rd_addr = i_ff;
      endcase
   end

   always_comb begin
      case (ctl.wa_sel)
         WA_I:    wr_addr = i_ff;
         WA_J:    wr_addr = j_ff;
         WA_X:    wr_addr = x_ff;
         WA_Y:    wr_addr = y_ff;
         default: wr_addr = i_ff;
      endcase
   end

   always_comb begin
      case (ctl.wd_sel)
         WD_I:    wr_data = i_ff;
         WD_RD:   wr_data = rd_ff;
         WD_T:    wr_data = t_ff;
         default: wr_data = rd_ff;
      endcase
   end

   // The read returns the old contents when it hits the entry written in the same cycle.
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         perm_mem[wr_addr] <= wr_data;
      end
      rd_ff <= perm_mem[rd_addr];
   end

   assign key_we = key_go & ({1'b0, req_key_index} < KEY_LEN_MAX);

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[req_key_index[KEY_AW-1:0]] <= req_byte_value;
      end
      kd_ff <= key_mem[k_ff];
   end

   always_comb begin
      if (key_length == '0) begin
         len_eff = KEY_LEN_W'(1);
      end else if (key_length > KEY_LEN_MAX) begin
         len_eff = KEY_LEN_MAX;
      end else begin
         len_eff = key_length;
      end
   end

   assign k_inc    = KEY_LEN_W'(k_ff) + KEY_LEN_W'(1);
   assign sect_inc = (sect_ff == SECT_LAST) ? '0 : sect_ff + SECT_W'(1);

   always_comb begin
      i_in         = ctl.inc_i ? i_ff + 8'd1 : i_ff;
      j_in         = ctl.ld_j ? j_sum : j_ff;
      x_in         = ctl.ld_x ? x_ff + 8'd1 : x_ff;
      y_in         = ctl.ld_y ? y_ff + rd_ff : y_ff;
      k_in         = k_ff;
      sect_in      = ctl.ld_out ? sect_inc : sect_ff;
      rsp_valid_in = ctl.ld_out | (rsp_valid_ff & rsp_stall);
      if (ctl.inc_k) begin
         k_in = (k_inc >= len_eff) ? '0 : k_inc[KEY_AW-1:0];
      end
      if (ctl.clr) begin
         j_in    = '0;
         x_in    = '0;
         y_in    = '0;
         k_in    = '0;
         sect_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         k_ff         <= '0;
         sect_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         k_ff         <= k_in;
         sect_ff      <= sect_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // When the keystream index equals y, the table entry was just rewritten with a.
   assign ks = hit_ff ? t_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.ld_t) begin
         t_ff <= rd_ff;
      end
      if (ctl.ld_b) begin
         b_ff <= rd_ff;
      end
      if (ctl.ld_hit) begin
         hit_ff <= (ab_sum == y_ff);
      end
      if (item_go) begin
         val_ff <= req_byte_value;
      end
      if (ctl.ld_out) begin
         out_byte_ff <= val_ff ^ ks;
      end
   end

   // A section count that is zero after this cycle means the next byte re-keys.
   assign status.i_last   = (i_ff == I_LAST);
   assign status.rsp_busy = rsp_valid_ff & rsp_stall;
   assign status.rekey    = req_message_start | (sect_in == '0);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;

endmodule

`default_nettype wire

// ----- rtl/rc4_stream_cipher_sectioned_core.sv -----
// Top level of the sectioned RC4 engine: register port, sequencer and datapath.
// A byte that re-keys first runs the key schedule (256 table fill steps and 4 mixing steps
// per table entry). A new byte is taken only in the idle step or the last step of the byte
// before, set by the dependent permutation memory accesses; that last step waits while a
// result is stalled. Key writes give no result. Synchronous reset clears the step counter,
// indices and output valid, sets key_length to 1 and makes a re-key pending.
`default_nettype none

module rc4_stream_cipher_sectioned_core
   import rc4s_pkg::*;
#(
   parameter int SECTION_BYTES = SECTION_BYTES_DEF,
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [7:0]            req_key_index,
   input  wire logic [7:0]            req_byte_value,
   input  wire logic                  req_message_start,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [7:0]            rsp_out_byte,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   logic [KEY_LEN_W-1:0] key_length_ff;
   logic                 csr_wr;
   dp_ctl_type           ctl;
   dp_status_type        status;
   logic                 key_go;
   logic                 item_go;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_RESET;
      end else if (csr_wr && csr_paddr == CSR_KEY_LENGTH) begin
         key_length_ff <= csr_pwdata[KEY_LEN_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_KEY_LENGTH) ?
                       {{(CSR_DATA_W-KEY_LEN_W){1'b0}}, key_length_ff} : '0;

   rc4s_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .status    (status),
      .ctl       (ctl),
      .req_stall (req_stall),
      .key_go    (key_go),
      .item_go   (item_go)
   );

   rc4s_datapath #(
      .SECTION_BYTES (SECTION_BYTES),
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .key_go            (key_go),
      .item_go           (item_go),
      .key_length        (key_length_ff),
      .req_key_index     (req_key_index),
      .req_byte_value    (req_byte_value),
      .req_message_start (req_message_start),
      .rsp_stall         (rsp_stall),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte)
   );

endmodule

`default_nettype wire

// ----- tb/sv/rc4_stream_cipher_sectioned_core_test.sv -----
// Self-checking testbench for the sectioned RC4 engine with a built-in cipher predictor.
`timescale 1ns / 1ps

module rc4_stream_cipher_sectioned_core_test;
   import rc4s_pkg::*;

   localparam int   SECTION_LEN   = 512;
   localparam int   KEY_SLOTS     = 256;
   localparam int   SETTLE_CYCLES = 20;

   typedef struct packed {
      logic       cmd;
      logic [7:0] key_index;
      logic [7:0] byte_value;
      logic       message_start;
   } cipher_req_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_cmd;
   logic [7:0]            req_key_index;
   logic [7:0]            req_byte_value;
   logic                  req_message_start;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_out_byte;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rc4_stream_cipher_sectioned_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_key_index     (req_key_index),
      .req_byte_value    (req_byte_value),
      .req_message_start (req_message_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Predictor state: the permutation, the key, the stream indices and the section position.
   logic [7:0]           perm_model [KEY_SLOTS];
   logic [7:0]           key_model [KEY_SLOTS];
   logic [7:0]           x_model;
   logic [7:0]           y_model;
   int                   section_pos;
   logic [KEY_LEN_W-1:0] key_len_model;

   cipher_req_type req_pending [$];
   logic [7:0]     expected_bytes [$];
   bit             key_written [KEY_SLOTS];
   bit             req_fired;
   bit             calm;
   int             req_gap_left;
   int             rsp_stall_left;
   int             mismatches;
   int             data_count;
   int             key_write_count;
   int             schedule_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      $display("MISMATCH at %0t: %s, got 8'h%02h, expected 8'h%02h", $realtime, what, got,
               want);
   endtask

   task automatic run_key_schedule();
      int         idx;
      int         k;
      int         len;
      logic [7:0] j;
      logic [7:0] t;
      len = (key_len_model == 0) ? 1 : ((key_len_model > KEY_SLOTS) ? KEY_SLOTS :
                                        int'(key_len_model));
      k = 0;
      j = 8'd0;
      for (idx = 0; idx < KEY_SLOTS; idx++) perm_model[idx] = idx[7:0];
      for (idx = 0; idx < KEY_SLOTS; idx++) begin
         t = perm_model[idx];
         j = j + t + key_model[k];
         perm_model[idx] = perm_model[j];
         perm_model[j] = t;
         k++;
         if (k >= len) k = 0;
      end
      x_model = 8'd0;
      y_model = 8'd0;
      schedule_count++;
   endtask

   // Advances the predictor by one accepted transfer and queues the byte it produces.
   task automatic cipher_accept(input cipher_req_type item);
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] sum;
      if (item.cmd == CMD_KEY_WRITE) begin
         key_model[item.key_index] = item.byte_value;
         key_write_count++;
      end else begin
         if (item.message_start || section_pos == 0) begin
            run_key_schedule();
            section_pos = 0;
         end
         x_model = x_model + 8'd1;
         a = perm_model[x_model];
         y_model = y_model + a;
         b = perm_model[y_model];
         perm_model[x_model] = b;
         perm_model[y_model] = a;
         sum = a + b;
         section_pos++;
         if (section_pos >= SECTION_LEN) section_pos = 0;
         expected_bytes.push_back(item.byte_value ^ perm_model[sum]);
         data_count++;
      end
   endtask

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         req_fired <= 1'b0;
         x_model = 8'd0;
         y_model = 8'd0;
         section_pos = 0;
         key_len_model = KEY_LEN_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_KEY_LENGTH) begin
            key_len_model = csr_pwdata[KEY_LEN_W-1:0];
         end
         if (req_valid && !req_stall) begin
            cipher_accept('{req_cmd, req_key_index, req_byte_value, req_message_start});
         end
         req_fired <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("result with no byte expected", rsp_out_byte, 8'h00);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want) report_mismatch("out_byte", rsp_out_byte, want);
            end
         end
      end
   end

   // Request driver. A presented transfer is held until the engine takes it.
   always @(negedge clock) begin
      cipher_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_fired) void'(req_pending.pop_front());
         if (req_valid && !req_fired) begin
            // Hold the stalled transfer unchanged.
         end else if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (req_pending.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            req_gap_left = $urandom_range(1, 12) - 1;
            req_valid <= 1'b0;
         end else begin
            item = req_pending[0];
            req_valid         <= 1'b1;
            req_cmd           <= item.cmd;
            req_key_index     <= item.key_index;
            req_byte_value    <= item.byte_value;
            req_message_start <= item.message_start;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void push_req(input logic cmd, input logic [7:0] key_index,
                                    input logic [7:0] byte_value, input logic message_start);
      req_pending.push_back('{cmd, key_index, byte_value, message_start});
      if (cmd == CMD_KEY_WRITE) key_written[key_index] = 1'b1;
   endfunction

   // Every key byte that a schedule may read must be written first.
   function automatic void cover_key(input int len);
      for (int idx = 0; idx < len; idx++) begin
         if (!key_written[idx]) push_req(CMD_KEY_WRITE, idx[7:0], 8'($urandom), 1'($urandom));
      end
   endfunction

   // Mostly data bytes in messages of random length, with key writes mixed in.
   function automatic void add_traffic(input int count, input int start_odds);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 7) == 0) begin
            push_req(CMD_KEY_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
         end else begin
            push_req(CMD_DATA, 8'($urandom), 8'($urandom),
                     start_odds != 0 && $urandom_range(0, start_odds - 1) == 0);
         end
      end
   endfunction

   task automatic wait_idle();
      while (req_pending.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_KEY_LENGTH;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cmd           = CMD_KEY_WRITE;
      req_key_index     = 8'd0;
      req_byte_value    = 8'd0;
      req_message_start = 1'b0;
      rsp_stall         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = CSR_KEY_LENGTH;
      csr_pwdata        = '0;
      calm              = 1'b0;
      req_gap_left      = 0;
      rsp_stall_left    = 0;
      mismatches        = 0;
      data_count        = 0;
      key_write_count   = 0;
      schedule_count    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset key length of one byte.
      push_req(CMD_KEY_WRITE, 8'd0, 8'h00, 1'b1);
      push_req(CMD_KEY_WRITE, 8'd255, 8'hFF, 1'b1);
      push_req(CMD_DATA, 8'd255, 8'h00, 1'b0);
      push_req(CMD_DATA, 8'd0, 8'hFF, 1'b0);
      push_req(CMD_DATA, 8'd0, 8'hA5, 1'b1);
      // A key change in the middle of a message waits for the next schedule.
      push_req(CMD_KEY_WRITE, 8'd0, 8'hFF, 1'b0);
      push_req(CMD_DATA, 8'd0, 8'h5A, 1'b0);
      push_req(CMD_DATA, 8'd0, 8'h3C, 1'b1);
      push_req(CMD_KEY_WRITE, 8'd128, 8'h80, 1'b0);
      push_req(CMD_KEY_WRITE, 8'd1, 8'h01, 1'b1);
      push_req(CMD_KEY_WRITE, 8'd127, 8'h7F, 1'b0);
      push_req(CMD_DATA, 8'hAA, 8'h55, 1'b1);
      for (int n = 0; n < 6; n++) push_req(CMD_DATA, 8'($urandom), 8'($urandom), 1'b0);
      push_req(CMD_DATA, 8'd0, 8'hFF, 1'b1);
      push_req(CMD_DATA, 8'd0, 8'h00, 1'b1);
      wait_idle();

      // A key length of zero acts as one.
      csr_write(32'd0);
      cover_key(1);
      add_traffic(250, 40);
      wait_idle();

      // The largest register value saturates to the full key store.
      csr_write(32'd511);
      cover_key(KEY_SLOTS);
      add_traffic(300, 50);
      wait_idle();

      // No message starts here, so the stream re-keys on section boundaries alone.
      csr_write(32'd256);
      add_traffic(700, 0);
      wait_idle();

      csr_write(32'd16);
      add_traffic(300, 20);
      wait_idle();

      calm = 1'b1;
      csr_write(CSR_DATA_W'($urandom_range(2, 255)));
      add_traffic(300, 30);
      wait_idle();

      $display("Checked %0d data bytes and %0d key writes across %0d key schedules,",
               data_count, key_write_count, schedule_count);
      $display("with key lengths of 0, 1, 16, 256, 511 and one random setting.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Timed out with %0d bytes still expected", expected_bytes.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rc4s_pkg.sv
rtl/rc4s_sequencer.sv
rtl/rc4s_datapath.sv
rtl/rc4_stream_cipher_sectioned_core.sv
tb/sv/rc4_stream_cipher_sectioned_core_test.sv
